// ===== rtl/fep_pkg.sv =====
// Package for the fire-effect pixel engine: item classes, queue control,
// intensity limits and the fire palette. No dependencies.
`default_nettype none

package fep_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ZERO = 2'd0;
	localparam kind_t KIND_DROP = 2'd1;
	localparam kind_t KIND_READ = 2'd2;
	localparam kind_t KIND_PROP = 2'd3;

	localparam logic OP_PROP = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [5:0] MAX_INTENSITY = 6'd36;
	localparam logic [1:0] MAX_DECAY = 2'd2;

	localparam int Q_DEPTH = 4;

	typedef struct packed {
		kind_t kind;
		logic [1:0] dec;
	} ctl_t;

	function automatic logic [23:0] palette_rgb(input logic [5:0] level);
		logic [23:0] rgb;
		case (level)
			6'd0: rgb = {8'd7, 8'd7, 8'd7};
			6'd1: rgb = {8'd31, 8'd7, 8'd7};
			6'd2: rgb = {8'd47, 8'd15, 8'd7};
			6'd3: rgb = {8'd71, 8'd15, 8'd7};
			6'd4: rgb = {8'd87, 8'd23, 8'd7};
			6'd5: rgb = {8'd103, 8'd31, 8'd7};
			6'd6: rgb = {8'd119, 8'd31, 8'd7};
			6'd7: rgb = {8'd143, 8'd39, 8'd7};
			6'd8: rgb = {8'd159, 8'd47, 8'd7};
			6'd9: rgb = {8'd175, 8'd63, 8'd7};
			6'd10: rgb = {8'd191, 8'd71, 8'd7};
			6'd11: rgb = {8'd199, 8'd71, 8'd7};
			6'd12: rgb = {8'd223, 8'd79, 8'd7};
			6'd13: rgb = {8'd223, 8'd87, 8'd7};
			6'd14: rgb = {8'd223, 8'd87, 8'd7};
			6'd15: rgb = {8'd215, 8'd95, 8'd7};
			6'd16: rgb = {8'd215, 8'd95, 8'd7};
			6'd17: rgb = {8'd215, 8'd103, 8'd15};
			6'd18: rgb = {8'd207, 8'd111, 8'd15};
			6'd19: rgb = {8'd207, 8'd119, 8'd15};
			6'd20: rgb = {8'd207, 8'd127, 8'd15};
			6'd21: rgb = {8'd207, 8'd135, 8'd23};
			6'd22: rgb = {8'd199, 8'd135, 8'd23};
			6'd23: rgb = {8'd199, 8'd143, 8'd23};
			6'd24: rgb = {8'd199, 8'd151, 8'd31};
			6'd25: rgb = {8'd191, 8'd159, 8'd31};
			6'd26: rgb = {8'd191, 8'd159, 8'd31};
			6'd27: rgb = {8'd191, 8'd167, 8'd39};
			6'd28: rgb = {8'd191, 8'd167, 8'd39};
			6'd29: rgb = {8'd191, 8'd175, 8'd47};
			6'd30: rgb = {8'd183, 8'd175, 8'd47};
			6'd31: rgb = {8'd183, 8'd183, 8'd47};
			6'd32: rgb = {8'd183, 8'd183, 8'd55};
			6'd33: rgb = {8'd207, 8'd207, 8'd111};
			6'd34: rgb = {8'd223, 8'd223, 8'd159};
			6'd35: rgb = {8'd239, 8'd239, 8'd199};
			default: rgb = {8'd255, 8'd255, 8'd255};
		endcase
		return rgb;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fire_effect_pixel_engine_core.sv =====
// Top level of the fire-effect pixel engine: front end, request queue and back end.
// Depends on fep_pkg, fep_front, fep_queue, fep_back.
//
// A request is taken at a rising edge where start is high and busy is low. The op
// port selects propagate (decay from the host's random source) or read at the
// pixel given by column and row. Every request gives exactly one result, shown
// on the result ports for one cycle while done is high; the receiver cannot
// hold results off.
// The front end registers the request and its row product, then pushes the
// classified request into a four-entry queue. The back end takes propagate and
// read requests as a store read, then registered read data and write-back, and
// pops no new request until both are done; requests that touch no store entry
// leave at one per cycle while the back end is idle and the queue holds them.
// Between accept and done lie the front-end registers, the queue entry and, for
// a store access, the wait state, when the queue is empty. busy is high while
// the store is cleared or the queue has no room. After reset the back end sweeps
// all FRAME_WIDTH * FRAME_HEIGHT store entries (38400 by default) one entry per
// cycle, zeroing them and writing full intensity on the bottom row; busy stays high.
`default_nettype none

module fire_effect_pixel_engine_core
	import fep_pkg::*;
#(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 160
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire        op,
	input  wire [7:0]  column,
	input  wire [7:0]  row,
	input  wire [1:0]  decay,
	output logic       done,
	output logic [5:0] intensity,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       written,
	output logic       dropped
);

	localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int EW = $bits(ctl_t) + 2 * AW;
	localparam int CW = $clog2(Q_DEPTH + 1);
	localparam int SW = $clog2(Q_DEPTH + 2);

	logic          accept;
	logic          push;
	logic [EW-1:0] push_data;
	logic          pop;
	logic [EW-1:0] head;
	logic [CW-1:0] count;
	logic          clearing;

	assign busy   = clearing || ((SW'(count) + SW'(push)) >= SW'(Q_DEPTH));
	assign accept = start && !busy;

	fep_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.AW           (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.column    (column),
		.row       (row),
		.decay     (decay),
		.push      (push),
		.push_data (push_data)
	);

	fep_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.count     (count)
	);

	fep_back #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.AW           (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (count == '0),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.intensity (intensity),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.written   (written),
		.dropped   (dropped)
	);

endmodule

`default_nettype wire

// ===== rtl/fep_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fep_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 38400
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fep_front.sv =====
// Front end of the fire-effect pixel engine: takes requests, classifies them
// and works out store addresses. Depends on fep_pkg.
`default_nettype none

module fep_front
	import fep_pkg::*;
#(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 160,
	parameter int AW = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire                  op,
	input  wire [7:0]            column,
	input  wire [7:0]            row,
	input  wire [1:0]            decay,
	output logic                 push,
	output logic [$bits(ctl_t)+2*AW-1:0] push_data
);

	logic          valid_s1;
	logic          op_s1;
	logic [7:0]    col_s1;
	logic [1:0]    dec_s1;
	logic [AW-1:0] prod_s1;
	logic          inframe_s1;
	logic          bottom_s1;

	logic [AW-1:0] idx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	ctl_t          ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			col_s1     <= column;
			dec_s1     <= (decay > MAX_DECAY) ? MAX_DECAY : decay;
			prod_s1    <= AW'(32'(row) * 32'(FRAME_WIDTH));
			inframe_s1 <= (32'(column) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));
			bottom_s1  <= (32'(row) + 32'd1) >= 32'(FRAME_HEIGHT);
		end
	end

	always_comb begin
		idx     = prod_s1 + AW'(col_s1);
		rd_addr = idx;
		wr_addr = idx - AW'(dec_s1);
		ctl.dec = dec_s1;
		if (!inframe_s1) begin
			ctl.kind = KIND_ZERO;
		end else if (op_s1 == OP_READ) begin
			ctl.kind = KIND_READ;
		end else if (bottom_s1) begin
			ctl.kind = KIND_ZERO;
		end else if (idx < AW'(dec_s1)) begin
			ctl.kind = KIND_DROP;
		end else begin
			ctl.kind = KIND_PROP;
			rd_addr  = idx + AW'(FRAME_WIDTH);
		end
	end

	assign push      = valid_s1;
	assign push_data = {ctl, rd_addr, wr_addr};

endmodule

`default_nettype wire

// ===== rtl/fep_queue.sv =====
// Short request queue between the front and back ends of the fire-effect
// pixel engine. Depends on fep_pkg.
`default_nettype none

module fep_queue
	import fep_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            push,
	input  wire [WIDTH-1:0]                push_data,
	input  wire                            pop,
	output logic [WIDTH-1:0]               head,
	output logic [$clog2(Q_DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [Q_DEPTH];
	logic [PW-1:0]    rd_ptr_q;
	logic [PW-1:0]    wr_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(Q_DEPTH) || pop))
		else $error("request queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("request queue underflow");

endmodule

`default_nettype wire

// ===== rtl/fep_back.sv =====
// Back end of the fire-effect pixel engine: clears the intensity store after
// reset, executes queued requests and registers results. Depends on fep_pkg, fep_ram.
`default_nettype none

module fep_back
	import fep_pkg::*;
#(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 160,
	parameter int AW = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_empty,
	input  wire [$bits(ctl_t)+2*AW-1:0]  head,
	output logic                         pop,
	output logic                         clearing,
	output logic                         done,
	output logic [5:0]                   intensity,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic                         written,
	output logic                         dropped
);

	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int BOTTOM = FRAME_WIDTH * (FRAME_HEIGHT - 1);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_WAIT = 1'b1;

	ctl_t          head_ctl;
	logic [AW-1:0] head_rd;
	logic [AW-1:0] head_wr;

	logic          state_q;
	ctl_t          ctl_q;
	logic [AW-1:0] wr_addr_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic          done_q;
	logic [5:0]    intensity_q;
	logic [23:0]   rgb_q;
	logic          written_q;
	logic          dropped_q;

	logic          ram_we;
	logic [AW-1:0] ram_wr_addr;
	logic [5:0]    ram_wr_data;
	logic          ram_re;
	logic [5:0]    ram_rd_data;
	logic [5:0]    level;
	logic          mem_op;

	assign {head_ctl, head_rd, head_wr} = head;

	assign pop    = (state_q == B_IDLE) && !clr_q && !q_empty;
	assign mem_op = (head_ctl.kind == KIND_READ) || (head_ctl.kind == KIND_PROP);
	assign ram_re = pop && mem_op;

	always_comb begin
		if (ctl_q.kind == KIND_PROP) begin
			level = (ram_rd_data >= 6'(ctl_q.dec)) ? ram_rd_data - 6'(ctl_q.dec) : 6'd0;
		end else begin
			level = ram_rd_data;
		end
		if (clr_q) begin
			ram_we      = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = (clr_addr_q >= AW'(BOTTOM)) ? MAX_INTENSITY : 6'd0;
		end else begin
			ram_we      = (state_q == B_WAIT) && (ctl_q.kind == KIND_PROP);
			ram_wr_addr = wr_addr_q;
			ram_wr_data = level;
		end
	end

	fep_ram #(
		.WIDTH(6),
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.re      (ram_re),
		.rd_addr (head_rd),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clr_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (mem_op) begin
							state_q <= B_WAIT;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				B_WAIT: begin
					state_q <= B_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_q       <= head_ctl;
			wr_addr_q   <= head_wr;
			intensity_q <= 6'd0;
			rgb_q       <= 24'd0;
			written_q   <= 1'b0;
			dropped_q   <= (head_ctl.kind == KIND_DROP);
		end else if (state_q == B_WAIT) begin
			intensity_q <= level;
			rgb_q       <= palette_rgb(level);
			written_q   <= (ctl_q.kind == KIND_PROP);
			dropped_q   <= 1'b0;
		end
	end

	assign clearing  = clr_q;
	assign done      = done_q;
	assign intensity = intensity_q;
	assign red       = rgb_q[23:16];
	assign green     = rgb_q[15:8];
	assign blue      = rgb_q[7:0];
	assign written   = written_q;
	assign dropped   = dropped_q;

	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !done_q && !pop)
		else $error("request handled during store clearing");
	a_wait_is_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WAIT) |=> (state_q == B_IDLE) && done_q)
		else $error("memory request did not complete");
	a_write_only_prop: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_q) |-> (state_q == B_WAIT) && (ctl_q.kind == KIND_PROP))
		else $error("store written outside a propagate");
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(written_q && dropped_q))
		else $error("result both written and dropped");

endmodule

`default_nettype wire
